@@ src/twaw_pkg.sv @@
// Shared types and constants for the tile window address walker.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package twaw_pkg;

  localparam int MOVE_BITS    = 33;
  localparam int ADDR_BITS    = 32;
  localparam int FIELD_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_WINDOW_LEFT   = 3'd2,
    REG_WINDOW_TOP    = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4,
    REG_WINDOW_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PLACE_INSIDE = 2'd0,
    PLACE_END    = 2'd1,
    PLACE_BEFORE = 2'd2,
    PLACE_SAT    = 2'd3
  } place_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_MOVE,
    ST_DIV,
    ST_MUL,
    ST_ADDR
  } state_e;

endpackage

@@ src/twaw_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Dividend is 2*WIDTH bits with quotient known to fit WIDTH bits. No package use.
`timescale 1ns / 1ps

module twaw_divider #(
  parameter int WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2*WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0]   divisor_i,
  output logic               done_o,
  output logic [WIDTH-1:0]   quotient_o,
  output logic [WIDTH-1:0]   remainder_o
);

  localparam int CntBits = $clog2(WIDTH);

  logic               busy_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [WIDTH-1:0]   rem_q, rem_d;
  logic [WIDTH-1:0]   quo_q, quo_d;
  logic [WIDTH-1:0]   div_q;
  logic [WIDTH:0]     trial;
  logic [WIDTH:0]     diff;
  logic               ge;
  logic               last;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_d = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  assign quo_d = {quo_q[WIDTH-2:0], ge};
  assign last  = (cnt_q == CntBits'(WIDTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[2*WIDTH-1:WIDTH];
      quo_q <= dividend_i[WIDTH-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

@@ src/tile_window_address_walker_unit.sv @@
// Top level of the tile window address walker: config registers, sequencer,
// shared multiplier and position update. Uses twaw_pkg and twaw_divider.
`timescale 1ns / 1ps

// Walks a rectangular tile inside a row-major image. Each input word may
// restart the position at the tile's first pixel and then moves it by a
// signed count, saturating at one before the start and at the end of the
// tile. One result word follows each input word. When the position lands
// inside or at the end of a tile of nonzero width, the bit-serial divider
// splits the position into row and column; otherwise the divider is skipped.
// One multiplier forms first the tile area and then the row offset.
// in_stall_o is high while a word is being worked on or its result cannot
// yet be handed off.

module tile_window_address_walker_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [twaw_pkg::CFG_IDX_BITS-1:0]     cfg_addr_i,
  input  logic [COORD_BITS-1:0]                 cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  restart_i,
  input  logic signed [twaw_pkg::MOVE_BITS-1:0] move_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [twaw_pkg::ADDR_BITS-1:0]        pixel_address_o,
  output logic [twaw_pkg::FIELD_BITS-1:0]       tile_col_o,
  output logic [twaw_pkg::FIELD_BITS-1:0]       tile_row_o,
  output logic [1:0]                            place_o,
  output logic                                  window_invalid_o
);

  localparam int CB  = COORD_BITS;
  localparam int MB  = twaw_pkg::MOVE_BITS;
  localparam int FB  = twaw_pkg::FIELD_BITS;
  localparam int AB  = twaw_pkg::ADDR_BITS;
  localparam int PW  = 2 * CB + 1;
  localparam int SW  = ((PW > MB) ? PW : MB) + 1;
  localparam int PRW = 2 * CB + 1;
  localparam int AW  = ((2 * CB + 2) > AB) ? (2 * CB + 2) : AB;

  localparam logic signed [SW-1:0] MinusOne = '1;

  // configuration
  logic [CB-1:0] img_w_q, img_h_q, win_l_q, win_t_q, win_w_q, win_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= '0;
      img_h_q <= '0;
      win_l_q <= '0;
      win_t_q <= '0;
      win_w_q <= '0;
      win_h_q <= '0;
    end else if (cfg_we_i) begin
      unique case (twaw_pkg::cfg_reg_e'(cfg_addr_i))
        twaw_pkg::REG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        twaw_pkg::REG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        twaw_pkg::REG_WINDOW_LEFT:   win_l_q <= cfg_data_i;
        twaw_pkg::REG_WINDOW_TOP:    win_t_q <= cfg_data_i;
        twaw_pkg::REG_WINDOW_WIDTH:  win_w_q <= cfg_data_i;
        twaw_pkg::REG_WINDOW_HEIGHT: win_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  twaw_pkg::state_e state_q, state_d;

  logic signed [PW-1:0] pos_q, pos_nxt;
  logic                 restart_q;
  logic signed [MB-1:0] count_q;
  logic [PRW-1:0]       prod_q;
  logic [CB-1:0]        row_q, col_q;
  twaw_pkg::place_e     place_q, place_nxt;
  logic                 out_valid_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic [CB-1:0]        div_quo, div_rem;

  logic signed [PW-1:0] base;
  logic signed [SW-1:0] sum_s, tot_s;
  logic                 need_div;
  logic [CB:0]          mul_a;
  logic [CB-1:0]        mul_b;
  logic [AW-1:0]        addr_w;
  logic                 invalid;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twaw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      twaw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = twaw_pkg::ST_TOTAL;
      end
      twaw_pkg::ST_TOTAL: state_d = twaw_pkg::ST_MOVE;
      twaw_pkg::ST_MOVE: begin
        div_start = need_div;
        state_d   = need_div ? twaw_pkg::ST_DIV : twaw_pkg::ST_MUL;
      end
      twaw_pkg::ST_DIV: begin
        if (div_done) state_d = twaw_pkg::ST_MUL;
      end
      twaw_pkg::ST_MUL: state_d = twaw_pkg::ST_ADDR;
      twaw_pkg::ST_ADDR: begin
        if (out_free) state_d = twaw_pkg::ST_IDLE;
      end
      default: state_d = twaw_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != twaw_pkg::ST_IDLE);

  // position update: add, compare against -1 and tile area, clamp
  assign base  = restart_q ? '0 : pos_q;
  assign sum_s = {{(SW - PW){base[PW-1]}}, base} + {{(SW - MB){count_q[MB-1]}}, count_q};
  assign tot_s = $signed(SW'(prod_q[2*CB-1:0]));

  always_comb begin
    pos_nxt   = PW'(sum_s);
    place_nxt = twaw_pkg::PLACE_INSIDE;
    if (sum_s < MinusOne) begin
      pos_nxt   = '1;
      place_nxt = twaw_pkg::PLACE_SAT;
    end else if (sum_s > tot_s) begin
      pos_nxt   = PW'(tot_s);
      place_nxt = twaw_pkg::PLACE_SAT;
    end else if (sum_s == tot_s) begin
      place_nxt = twaw_pkg::PLACE_END;
    end else if (sum_s == MinusOne) begin
      place_nxt = twaw_pkg::PLACE_BEFORE;
    end
  end

  assign need_div = !pos_nxt[PW-1] && (win_w_q != '0);

  // shared multiplier operands
  always_comb begin
    if (state_q == twaw_pkg::ST_TOTAL) begin
      mul_a = {1'b0, win_w_q};
      mul_b = win_h_q;
    end else begin
      mul_a = {1'b0, win_t_q} + {1'b0, row_q};
      mul_b = img_w_q;
    end
  end

  assign addr_w = AW'(prod_q) + AW'(win_l_q) + AW'(col_q) - AW'(pos_q[PW-1]);

  assign invalid = (win_w_q == '0)
                || (({1'b0, win_l_q} + {1'b0, win_w_q}) > {1'b0, img_w_q})
                || (({1'b0, win_t_q} + {1'b0, win_h_q}) > {1'b0, img_h_q});

  twaw_divider #(
    .WIDTH(CB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pos_nxt[2*CB-1:0]),
    .divisor_i  (win_w_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == twaw_pkg::ST_MOVE) pos_q <= pos_nxt;
      if (state_q == twaw_pkg::ST_ADDR && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      restart_q <= restart_i;
      count_q   <= move_count_i;
    end
    if (state_q == twaw_pkg::ST_TOTAL || state_q == twaw_pkg::ST_MUL) begin
      prod_q <= PRW'(mul_a * mul_b);
    end
    if (state_q == twaw_pkg::ST_MOVE) begin
      place_q <= place_nxt;
      row_q   <= '0;
      col_q   <= '0;
    end else if (state_q == twaw_pkg::ST_DIV && div_done) begin
      row_q <= div_quo;
      col_q <= div_rem;
    end
    if (state_q == twaw_pkg::ST_ADDR && out_free) begin
      pixel_address_o  <= AB'(addr_w);
      tile_col_o       <= FB'(col_q);
      tile_row_o       <= FB'(row_q);
      place_o          <= place_q;
      window_invalid_o <= invalid;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
